// ===== src/pooling_window_generator_defines.svh =====
// assertion macros for the pooling window generator
`ifndef POOLING_WINDOW_GENERATOR_DEFINES_SVH
`define POOLING_WINDOW_GENERATOR_DEFINES_SVH

// clocked property, idle during reset
`define PWG_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// a condition that must never be seen
`define PWG_ASSERT_NEVER(label, cond, msg) \
    `PWG_ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/pwg_pkg.sv =====
// shared constants and types for the pooling window generator
`timescale 1ns / 1ps
`default_nettype none

package pwg_pkg;

    localparam int COORD_BITS  = 10;
    localparam int KERNEL_BITS = 4;

    // signed width of the origin arithmetic: product, pad and kernel sum
    localparam int ARITH_BITS = COORD_BITS + KERNEL_BITS + 2;

    localparam int CFG_DATA_BITS = (COORD_BITS > KERNEL_BITS) ?
                                   2 * COORD_BITS : 2 * KERNEL_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_BEGIN    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_SIZE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_SIZE  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_CHANNELS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WALK_ORDER   = 3'd6;

    // walk orders
    localparam logic [1:0] WALK_SPATIAL = 2'd0;
    localparam logic [1:0] WALK_XYC     = 2'd1;
    localparam logic [1:0] WALK_CXY     = 2'd2;

    typedef struct packed {
        logic [KERNEL_BITS-1:0] stride_x;
        logic [KERNEL_BITS-1:0] stride_y;
        logic [KERNEL_BITS-1:0] kernel_w;
        logic [KERNEL_BITS-1:0] kernel_h;
        logic [KERNEL_BITS-1:0] pad_l;
        logic [KERNEL_BITS-1:0] pad_t;
        logic [COORD_BITS-1:0]  in_w;
        logic [COORD_BITS-1:0]  in_h;
        logic [COORD_BITS-1:0]  out_w;
        logic [COORD_BITS-1:0]  out_h;
        logic [COORD_BITS-1:0]  out_ch;
        logic [1:0]             walk_order;
    } cfg_t;

    // one position handed from the walker to the window stage
    typedef struct packed {
        logic                  win_valid;
        logic                  last;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] c;
    } walk_item_t;

endpackage

`default_nettype wire

// ===== src/pwg_walker.sv =====
// position state, walk-order advance and first pipeline register
`timescale 1ns / 1ps
`default_nettype none

module pwg_walker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  pwg_pkg::cfg_t          cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              restart,
    output logic                   item_valid,
    output pwg_pkg::walk_item_t    item,
    input  wire logic              item_ready
);
    import pwg_pkg::*;

    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg, pos_c_reg;
    logic [COORD_BITS-1:0] pos_x_next, pos_y_next, pos_c_next;
    logic                  finished_reg, finished_next;
    logic                  item_valid_reg;
    walk_item_t            item_reg, item_next;

    logic [COORD_BITS-1:0] cur_x, cur_y, cur_c;
    logic                  cur_fin;
    logic [COORD_BITS:0]   ax, ay, ac;
    logic                  done;
    logic                  accept;

    assign in_ready   = !item_valid_reg || item_ready;
    assign accept     = in_valid && in_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // restart takes effect before this transaction's window
    assign cur_x   = restart ? '0 : pos_x_reg;
    assign cur_y   = restart ? '0 : pos_y_reg;
    assign cur_c   = restart ? '0 : pos_c_reg;
    assign cur_fin = restart ? 1'b0 : finished_reg;

    // advance one step in the configured order
    always_comb begin
        ax = {1'b0, cur_x};
        ay = {1'b0, cur_y};
        ac = {1'b0, cur_c};
        case (cfg.walk_order)
            WALK_XYC: begin
                ax = ax + 1'b1;
                if (ax >= {1'b0, cfg.out_w}) begin
                    ax = '0;
                    ay = ay + 1'b1;
                end
                if (ay >= {1'b0, cfg.out_h}) begin
                    ay = '0;
                    ac = ac + 1'b1;
                end
                done = (ac >= {1'b0, cfg.out_ch});
            end
            WALK_CXY: begin
                ac = ac + 1'b1;
                if (ac >= {1'b0, cfg.out_ch}) begin
                    ac = '0;
                    ax = ax + 1'b1;
                end
                if (ax >= {1'b0, cfg.out_w}) begin
                    ax = '0;
                    ay = ay + 1'b1;
                end
                done = (ay >= {1'b0, cfg.out_h});
            end
            default: begin
                ax = ax + 1'b1;
                if (ax >= {1'b0, cfg.out_w}) begin
                    ax = '0;
                    ay = ay + 1'b1;
                end
                done = (ay >= {1'b0, cfg.out_h});
            end
        endcase
        if (done) begin
            ax = '0;
            ay = '0;
            ac = '0;
        end
    end

    // next state: a finished walker holds still
    always_comb begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_c_next    = pos_c_reg;
        finished_next = finished_reg;
        if (accept) begin
            pos_x_next    = cur_x;
            pos_y_next    = cur_y;
            pos_c_next    = cur_c;
            finished_next = cur_fin;
            if (!cur_fin) begin
                pos_x_next    = ax[COORD_BITS-1:0];
                pos_y_next    = ay[COORD_BITS-1:0];
                pos_c_next    = ac[COORD_BITS-1:0];
                finished_next = done;
            end
        end
    end

    // descriptor of the window to build
    always_comb begin
        item_next.win_valid = !cur_fin;
        item_next.last      = !cur_fin && done;
        item_next.x         = cur_x;
        item_next.y         = cur_y;
        item_next.c         = cur_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            pos_c_reg      <= '0;
            finished_reg   <= 1'b0;
            item_valid_reg <= 1'b0;
        end else begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_c_reg    <= pos_c_next;
            finished_reg <= finished_next;
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pwg_clip_axis.sv =====
// origin and edge clipping of the kernel along one axis
`timescale 1ns / 1ps
`default_nettype none

module pwg_clip_axis (
    input  wire logic [pwg_pkg::COORD_BITS-1:0]  pos,
    input  wire logic [pwg_pkg::KERNEL_BITS-1:0] stride,
    input  wire logic [pwg_pkg::KERNEL_BITS-1:0] pad,
    input  wire logic [pwg_pkg::KERNEL_BITS-1:0] ksize,
    input  wire logic [pwg_pkg::COORD_BITS-1:0]  isize,
    output logic [pwg_pkg::COORD_BITS-1:0]       origin,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      eff,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      off,
    output logic                                 lo,
    output logic                                 hi
);
    import pwg_pkg::*;

    logic        [ARITH_BITS-1:0] prod;
    logic signed [ARITH_BITS-1:0] org_raw, neg_org, k_lo, org_lo, k_fin;
    logic signed [ARITH_BITS-1:0] isize_s, ksize_s, cmax_s;

    assign isize_s = $signed(ARITH_BITS'(isize));
    assign ksize_s = $signed(ARITH_BITS'(ksize));
    assign cmax_s  = $signed(ARITH_BITS'(COORD_MAX));

    // origin = position * stride - leading pad
    assign prod    = ARITH_BITS'(pos) * ARITH_BITS'(stride);
    assign org_raw = $signed(prod - ARITH_BITS'(pad));
    assign neg_org = -org_raw;

    // low edge: trim the kernel by the part that falls before zero
    assign lo     = org_raw[ARITH_BITS-1];
    assign k_lo   = lo ? (ksize_s + org_raw) : ksize_s;
    assign org_lo = lo ? '0 : org_raw;
    assign off    = lo ? neg_org[KERNEL_BITS-1:0] : '0;

    // high edge: trim to the input size, clamp at zero
    assign hi    = (org_lo + k_lo) > isize_s;
    assign k_fin = hi ? (isize_s - org_lo) : k_lo;
    assign eff   = k_fin[ARITH_BITS-1] ? '0 : k_fin[KERNEL_BITS-1:0];

    // saturate the reported origin
    assign origin = (org_lo > cmax_s) ? COORD_MAX : org_lo[COORD_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/pwg_window.sv =====
// window descriptor build and result register
`timescale 1ns / 1ps
`default_nettype none

module pwg_window (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  pwg_pkg::cfg_t                        cfg,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  pwg_pkg::walk_item_t                  item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_window_valid,
    output logic                                 m_last_window,
    output logic [pwg_pkg::COORD_BITS-1:0]       m_out_x,
    output logic [pwg_pkg::COORD_BITS-1:0]       m_out_y,
    output logic [pwg_pkg::COORD_BITS-1:0]       m_out_c,
    output logic [pwg_pkg::COORD_BITS-1:0]       m_in_x,
    output logic [pwg_pkg::COORD_BITS-1:0]       m_in_y,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      m_kernel_w_eff,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      m_kernel_h_eff,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      m_kernel_off_w,
    output logic [pwg_pkg::KERNEL_BITS-1:0]      m_kernel_off_h,
    output logic [3:0]                           m_pad_flags
);
    import pwg_pkg::*;

    logic                   m_valid_reg;
    logic                   load;
    logic [COORD_BITS-1:0]  ix, iy;
    logic [KERNEL_BITS-1:0] kw, kh, ow, oh;
    logic                   l, r, t, b;
    logic                   wv;

    logic                   win_valid_reg, last_reg;
    logic [COORD_BITS-1:0]  out_x_reg, out_y_reg, out_c_reg, in_x_reg, in_y_reg;
    logic [KERNEL_BITS-1:0] kw_reg, kh_reg, ow_reg, oh_reg;
    logic [3:0]             pad_flags_reg;

    assign item_ready = !m_valid_reg || m_ready;
    assign load       = item_valid && item_ready;
    assign wv         = item.win_valid;

    pwg_clip_axis u_clip_x (
        .pos    (item.x),
        .stride (cfg.stride_x),
        .pad    (cfg.pad_l),
        .ksize  (cfg.kernel_w),
        .isize  (cfg.in_w),
        .origin (ix),
        .eff    (kw),
        .off    (ow),
        .lo     (l),
        .hi     (r)
    );

    pwg_clip_axis u_clip_y (
        .pos    (item.y),
        .stride (cfg.stride_y),
        .pad    (cfg.pad_t),
        .ksize  (cfg.kernel_h),
        .isize  (cfg.in_h),
        .origin (iy),
        .eff    (kh),
        .off    (oh),
        .lo     (t),
        .hi     (b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_ready) begin
            m_valid_reg <= item_valid;
        end
    end

    // result payload, all zero once the pass is finished
    always_ff @(posedge aclk) begin
        if (load) begin
            win_valid_reg <= wv;
            last_reg      <= item.last;
            out_x_reg     <= wv ? item.x : '0;
            out_y_reg     <= wv ? item.y : '0;
            out_c_reg     <= wv ? item.c : '0;
            in_x_reg      <= wv ? ix : '0;
            in_y_reg      <= wv ? iy : '0;
            kw_reg        <= wv ? kw : '0;
            kh_reg        <= wv ? kh : '0;
            ow_reg        <= wv ? ow : '0;
            oh_reg        <= wv ? oh : '0;
            pad_flags_reg <= wv ? {b, r, l, t} : 4'b0000;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_valid = win_valid_reg;
    assign m_last_window  = last_reg;
    assign m_out_x        = out_x_reg;
    assign m_out_y        = out_y_reg;
    assign m_out_c        = out_c_reg;
    assign m_in_x         = in_x_reg;
    assign m_in_y         = in_y_reg;
    assign m_kernel_w_eff = kw_reg;
    assign m_kernel_h_eff = kh_reg;
    assign m_kernel_off_w = ow_reg;
    assign m_kernel_off_h = oh_reg;
    assign m_pad_flags    = pad_flags_reg;

endmodule

`default_nettype wire

// ===== src/pooling_window_generator.sv =====
// top level of the pooling window generator
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_restart
//  m_        out        m_valid / m_ready   window descriptor fields
//  cfg_      in         cfg_we              cfg_index, cfg_data
//
// one transaction per cycle sustained while m_ready is high; the walker updates
// the position and registers the item on accepting, the window stage multiplies
// by stride and clips from that register, then the result register holds it
// synchronous active-low reset, no clearing pass; a stalled result register
// lets one more transaction enter the walker register before input stalls
`timescale 1ns / 1ps
`default_nettype none
`include "pooling_window_generator_defines.svh"

module pooling_window_generator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_restart,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_window_valid,
    output logic                                     m_last_window,
    output logic [pwg_pkg::COORD_BITS-1:0]           m_out_x,
    output logic [pwg_pkg::COORD_BITS-1:0]           m_out_y,
    output logic [pwg_pkg::COORD_BITS-1:0]           m_out_c,
    output logic [pwg_pkg::COORD_BITS-1:0]           m_in_x,
    output logic [pwg_pkg::COORD_BITS-1:0]           m_in_y,
    output logic [pwg_pkg::KERNEL_BITS-1:0]          m_kernel_w_eff,
    output logic [pwg_pkg::KERNEL_BITS-1:0]          m_kernel_h_eff,
    output logic [pwg_pkg::KERNEL_BITS-1:0]          m_kernel_off_w,
    output logic [pwg_pkg::KERNEL_BITS-1:0]          m_kernel_off_h,
    output logic [3:0]                               m_pad_flags,
    input  wire logic                                cfg_we,
    input  wire logic [pwg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [pwg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import pwg_pkg::*;

    cfg_t       cfg_reg;
    logic       item_valid, item_ready;
    walk_item_t item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stride_x   <= KERNEL_BITS'(1);
            cfg_reg.stride_y   <= KERNEL_BITS'(1);
            cfg_reg.kernel_w   <= KERNEL_BITS'(1);
            cfg_reg.kernel_h   <= KERNEL_BITS'(1);
            cfg_reg.pad_l      <= '0;
            cfg_reg.pad_t      <= '0;
            cfg_reg.in_w       <= COORD_BITS'(1);
            cfg_reg.in_h       <= COORD_BITS'(1);
            cfg_reg.out_w      <= COORD_BITS'(1);
            cfg_reg.out_h      <= COORD_BITS'(1);
            cfg_reg.out_ch     <= COORD_BITS'(1);
            cfg_reg.walk_order <= WALK_SPATIAL;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STRIDE: begin
                    cfg_reg.stride_x <= cfg_data[KERNEL_BITS-1:0];
                    cfg_reg.stride_y <= cfg_data[2*KERNEL_BITS-1:KERNEL_BITS];
                end
                REG_KERNEL: begin
                    cfg_reg.kernel_w <= cfg_data[KERNEL_BITS-1:0];
                    cfg_reg.kernel_h <= cfg_data[2*KERNEL_BITS-1:KERNEL_BITS];
                end
                REG_PAD_BEGIN: begin
                    cfg_reg.pad_l <= cfg_data[KERNEL_BITS-1:0];
                    cfg_reg.pad_t <= cfg_data[2*KERNEL_BITS-1:KERNEL_BITS];
                end
                REG_INPUT_SIZE: begin
                    cfg_reg.in_w <= cfg_data[COORD_BITS-1:0];
                    cfg_reg.in_h <= cfg_data[2*COORD_BITS-1:COORD_BITS];
                end
                REG_OUTPUT_SIZE: begin
                    cfg_reg.out_w <= cfg_data[COORD_BITS-1:0];
                    cfg_reg.out_h <= cfg_data[2*COORD_BITS-1:COORD_BITS];
                end
                REG_OUT_CHANNELS: begin
                    cfg_reg.out_ch <= cfg_data[COORD_BITS-1:0];
                end
                REG_WALK_ORDER: begin
                    cfg_reg.walk_order <= cfg_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pwg_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .restart    (s_restart),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    pwg_window u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_valid (m_window_valid),
        .m_last_window  (m_last_window),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_c        (m_out_c),
        .m_in_x         (m_in_x),
        .m_in_y         (m_in_y),
        .m_kernel_w_eff (m_kernel_w_eff),
        .m_kernel_h_eff (m_kernel_h_eff),
        .m_kernel_off_w (m_kernel_off_w),
        .m_kernel_off_h (m_kernel_off_h),
        .m_pad_flags    (m_pad_flags)
    );

    // checks
    `PWG_ASSERT_NEVER(a_last_needs_window, m_valid && m_last_window && !m_window_valid, "last window flagged on an empty result")
    `PWG_ASSERT_CLK(a_left_flag_offset, m_valid && m_window_valid |-> (m_pad_flags[1] == (m_kernel_off_w != '0)), "left pad flag disagrees with column offset")
    `PWG_ASSERT_CLK(a_top_flag_offset, m_valid && m_window_valid |-> (m_pad_flags[0] == (m_kernel_off_h != '0)), "top pad flag disagrees with row offset")
    `PWG_ASSERT_NEVER(a_empty_is_zero, m_valid && !m_window_valid && (m_pad_flags != 4'b0000 || m_kernel_w_eff != '0), "finished result carries nonzero fields")

endmodule

`default_nettype wire
